/* rtl/cwq_pkg.sv */
// Shared types and constants for the config word quoter.
// Used by cwq_front, cwq_queue, cwq_back and conf_word_quoter_unit.
package cwq_pkg;

  localparam int unsigned MAX_BYTES = 4;
  localparam int unsigned IDX_W     = $clog2(MAX_BYTES);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [7:0] char_in;
    logic       first_byte;
    logic       last_byte;
    logic       empty_word;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       end_of_run;
  } out_word_t;

  // Quoted bytes of one input word; last_idx marks the final one.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [IDX_W-1:0]          last_idx;
  } cwq_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } cwq_q_stat_t;

endpackage

/* rtl/cwq_front.sv */
// Front end: holds the quote mode and expands one input word into 1..4 bytes.
// Depends on cwq_pkg.
module cwq_front import cwq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_word_t   in_word,
  input  logic       accept,
  output cwq_entry_t entry
);

  typedef enum logic [1:0] {
    MODE_UNQ = 2'd0,
    MODE_SGL = 2'd1,
    MODE_DBL = 2'd2
  } mode_t;

  mode_t mode_r, mode_nxt;

  logic [7:0] c;
  logic       is_sp;
  logic       is_esc;

  assign c      = in_word.char_in;
  assign is_sp  = (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_esc = (c == CH_BSLASH) || (c == CH_SQUOTE) || (c == CH_DQUOTE);

  always_comb begin
    logic [MAX_BYTES-1:0][7:0] b;
    logic [IDX_W:0]            n;
    mode_t                     m;
    b = '0;
    n = '0;
    m = in_word.first_byte ? MODE_UNQ : mode_r;
    if (in_word.empty_word) begin
      b[0] = CH_SQUOTE;
      b[1] = CH_SQUOTE;
      n    = (IDX_W+1)'(2);
      m    = MODE_UNQ;
    end else begin
      case (m)
        MODE_SGL: begin
          if (is_sp || (c == CH_DQUOTE)) begin
            b[0] = c;
            n    = (IDX_W+1)'(1);
          end else if ((c == CH_BSLASH) || (c == CH_SQUOTE)) begin
            b[0] = CH_SQUOTE;
            b[1] = CH_BSLASH;
            b[2] = c;
            n    = (IDX_W+1)'(3);
            m    = MODE_UNQ;
          end else begin
            b[0] = CH_SQUOTE;
            b[1] = c;
            n    = (IDX_W+1)'(2);
            m    = MODE_UNQ;
          end
        end
        MODE_DBL: begin
          if (c == CH_BSLASH) begin
            b[0] = CH_BSLASH;
            b[1] = CH_BSLASH;
            n    = (IDX_W+1)'(2);
          end else if (c == CH_SQUOTE) begin
            b[0] = c;
            n    = (IDX_W+1)'(1);
          end else if (c == CH_DQUOTE) begin
            b[0] = CH_DQUOTE;
            b[1] = CH_BSLASH;
            b[2] = CH_DQUOTE;
            n    = (IDX_W+1)'(3);
            m    = MODE_UNQ;
          end else if (is_sp) begin
            b[0] = CH_DQUOTE;
            b[1] = CH_SQUOTE;
            b[2] = c;
            n    = (IDX_W+1)'(3);
            m    = MODE_SGL;
          end else begin
            b[0] = CH_DQUOTE;
            b[1] = c;
            n    = (IDX_W+1)'(2);
            m    = MODE_UNQ;
          end
        end
        default: begin
          if (is_esc) begin
            b[0] = CH_BSLASH;
            b[1] = c;
            n    = (IDX_W+1)'(2);
          end else if (is_sp) begin
            b[0] = CH_SQUOTE;
            b[1] = c;
            n    = (IDX_W+1)'(2);
            m    = MODE_SGL;
          end else if (in_word.first_byte && (c == CH_HASH)) begin
            b[0] = CH_DQUOTE;
            b[1] = c;
            n    = (IDX_W+1)'(2);
            m    = MODE_DBL;
          end else begin
            b[0] = c;
            n    = (IDX_W+1)'(1);
          end
        end
      endcase
      // closing quote; at most three bytes precede it
      if (in_word.last_byte) begin
        if (m == MODE_SGL) begin
          b[n[IDX_W-1:0]] = CH_SQUOTE;
          n = n + 1'b1;
        end else if (m == MODE_DBL) begin
          b[n[IDX_W-1:0]] = CH_DQUOTE;
          n = n + 1'b1;
        end
        m = MODE_UNQ;
      end
    end
    entry.bytes    = b;
    entry.last_idx = IDX_W'(n - 1'b1);
    mode_nxt       = m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UNQ;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

/* rtl/cwq_queue.sv */
// Short queue of expanded words between front and back ends.
// Depends on cwq_pkg.
module cwq_queue import cwq_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cwq_entry_t  wr_data,
  input  logic        pop,
  output cwq_entry_t  rd_data,
  output cwq_q_stat_t stat
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cwq_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.valid = (cnt_r != '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign rd_data    = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/cwq_back.sv */
// Back end: holds one expanded word and hands out its bytes one per pop.
// Depends on cwq_pkg.
module cwq_back import cwq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cwq_q_stat_t q_stat,
  input  cwq_entry_t  q_data,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output out_word_t   out_word
);

  cwq_entry_t       cur_r;
  logic             cur_valid_r;
  logic [IDX_W-1:0] idx_r;
  logic             advance, finish;

  assign empty               = !cur_valid_r;
  assign out_word.byte_out   = cur_r.bytes[idx_r];
  assign out_word.end_of_run = (idx_r == cur_r.last_idx);
  assign advance             = pop && cur_valid_r;
  assign finish              = advance && out_word.end_of_run;
  assign q_pop               = q_stat.valid && (!cur_valid_r || finish);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (finish) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (advance) begin
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule

/* rtl/conf_word_quoter_unit.sv */
// Config word quoter top level: front end, word queue, back end.
// Depends on cwq_pkg, cwq_front, cwq_queue, cwq_back.
//
//   channel  ports                     word
//   input    push, full, in_word       one byte of the word plus word marks
//   result   empty, pop, out_word      one byte of quoted text
//
// Each input word expands to 1..4 result words; the back end sends one per cycle while pop
// is held, and new input words can be pushed while earlier ones are still being sent.
// An input word is written into the queue when pushed, then loaded into the back end register, which drives out_word.
// The queue holds QUEUE_DEPTH expanded words; full rises when it is out of room.
// Synchronous active-low reset clears the quote mode, the queue and the back end.
module conf_word_quoter_unit import cwq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  cwq_entry_t  f_entry, q_data;
  cwq_q_stat_t q_stat;
  logic        accept, q_pop;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  cwq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .accept  (accept),
    .entry   (f_entry)
  );

  cwq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (f_entry),
    .pop     (q_pop),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  cwq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && !out_word.end_of_run |=> !empty)
    else $error("result stream stopped inside a run");

  a_back_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.valid && empty |=> !empty)
    else $error("back end idle while queue holds a word");

endmodule

/* verif/testbench.sv */
// Testbench for conf_word_quoter_unit: directed table, then random words.
// Quoted bytes are predicted per input word (or taken from the directed table) and checked in order at the pop side.
// Depends on cwq_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module testbench;
  import cwq_pkg::*;

  localparam int RAND_WORDS  = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_WAIT  = 20;

  typedef enum logic [1:0] {
    M_PLAIN  = 2'd0,
    M_SINGLE = 2'd1,
    M_DOUBLE = 2'd2,
    M_UNUSED = 2'd3
  } qmode_t;

  typedef logic [7:0] byte_q_t[$];

  // n == 0: expectation comes from the predictor
  typedef struct {
    in_word_t    w;
    int          n;
    logic [31:0] b;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_word_t  in_word = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_word_t out_word;

  qmode_t    held_mode = M_PLAIN;
  out_word_t quoted_q[$];
  out_word_t exp_w;
  int        errs = 0;
  int        cyc_cnt = 0;
  bit        calm = 1'b0;
  bit        hold_go = 1'b0;
  bit        hold_seen = 1'b0;
  int        hold_left = 0;
  dir_row_t  dir_tab[26];

  conf_word_quoter_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .empty   (empty),
    .pop     (pop),
    .out_word(out_word)
  );

  always #2 clk = ~clk;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Quoted bytes for one input word; advances held_mode.
  function automatic void quote_step(input in_word_t w, output byte_q_t q);
    qmode_t     m;
    logic [7:0] c;
    bit         done;
    int         i;
    q = {};
    c = w.char_in;
    m = held_mode;
    done = 1'b0;
    if (w.empty_word) begin
      q = '{CH_SQUOTE, CH_SQUOTE};
      held_mode = M_PLAIN;
      return;
    end
    if (w.first_byte || m == M_UNUSED) m = M_PLAIN;
    for (i = 0; i < 4 && !done; i++) begin
      case (m)
        M_SINGLE: begin
          if (c == CH_NUL || c == CH_DQUOTE || is_blank(c)) begin
            q.push_back(c);
            done = 1'b1;
          end else begin
            q.push_back(CH_SQUOTE);
            m = M_PLAIN;
          end
        end
        M_DOUBLE: begin
          if (c == CH_BSLASH) begin
            q.push_back(CH_BSLASH);
            q.push_back(CH_BSLASH);
            done = 1'b1;
          end else if (c == CH_SQUOTE || (w.first_byte && c == CH_HASH)) begin
            q.push_back(c);
            done = 1'b1;
          end else begin
            q.push_back(CH_DQUOTE);
            m = M_PLAIN;
          end
        end
        default: begin
          if (c == CH_BSLASH || c == CH_SQUOTE || c == CH_DQUOTE) begin
            q.push_back(CH_BSLASH);
            q.push_back(c);
            done = 1'b1;
          end else if (c == CH_NUL || is_blank(c)) begin
            q.push_back(CH_SQUOTE);
            m = M_SINGLE;
          end else if (w.first_byte && c == CH_HASH) begin
            q.push_back(CH_DQUOTE);
            m = M_DOUBLE;
          end else begin
            q.push_back(c);
            done = 1'b1;
          end
        end
      endcase
    end
    if (w.last_byte) begin
      if (m == M_SINGLE) q.push_back(CH_SQUOTE);
      else if (m == M_DOUBLE) q.push_back(CH_DQUOTE);
      m = M_PLAIN;
    end
    while (q.size() > MAX_BYTES) void'(q.pop_back());
    held_mode = m;
  endfunction

  function automatic dir_row_t row(logic [7:0] c, logic f, logic l, logic e,
                                   int n = 0, logic [31:0] b = '0);
    dir_row_t r;
    r.w = '{char_in: c, first_byte: f, last_byte: l, empty_word: e};
    r.n = n;
    r.b = b;
    return r;
  endfunction

  function automatic logic [7:0] pick_char(bit lead);
    logic [7:0] specials[5];
    specials = '{CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_HASH, CH_NUL};
    if (lead && $urandom_range(3) == 0) return CH_HASH;
    case ($urandom_range(5))
      0: return specials[$urandom_range(4)];
      1: return ($urandom_range(1) == 0) ? CH_SPACE : 8'($urandom_range(13, 9));
      2, 3: return 8'($urandom_range(8'h7E, 8'h21));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offer one word at a falling edge; record its quoted bytes when accepted.
  task automatic send_word(in_word_t w, int n = 0, logic [31:0] b = '0);
    byte_q_t q;
    while (!calm && $urandom_range(99) < 28) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
    quote_step(w, q);
    if (n > 0) begin
      q = {};
      for (int i = 0; i < n; i++) q.push_back(b[31 - 8 * i -: 8]);
    end
    foreach (q[i]) quoted_q.push_back('{byte_out: q[i], end_of_run: i == q.size() - 1});
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= calm || $urandom_range(99) >= 28;
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (quoted_q.size() == 0) begin
        errs++;
        $error("unexpected word: byte_out %h end_of_run %b",
               out_word.byte_out, out_word.end_of_run);
      end else begin
        exp_w = quoted_q.pop_front();
        if (out_word.byte_out !== exp_w.byte_out) begin
          errs++;
          $error("byte_out: expected %h, got %h", exp_w.byte_out, out_word.byte_out);
        end
        if (out_word.end_of_run !== exp_w.end_of_run) begin
          errs++;
          $error("end_of_run: expected %b, got %b", exp_w.end_of_run, out_word.end_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int       sent;
    int       len;
    dir_tab = '{
      row(8'hFF,      1, 1, 1, 2, 32'h2727_0000),  // empty word, char ignored
      row(8'h61,      1, 1, 0, 1, 32'h6100_0000),
      row(CH_NUL,     1, 1, 0, 3, 32'h2700_2700),
      row(8'hFF,      1, 1, 0, 1, 32'hFF00_0000),
      row(8'h80,      1, 1, 0, 1, 32'h8000_0000),
      row(CH_BSLASH,  1, 1, 0, 2, 32'h5C5C_0000),
      row(CH_SQUOTE,  1, 1, 0, 2, 32'h5C27_0000),
      row(CH_DQUOTE,  1, 1, 0, 2, 32'h5C22_0000),
      row(CH_HASH,    1, 1, 0, 3, 32'h2223_2200),
      row(CH_SPACE,   1, 1, 0, 3, 32'h2720_2700),
      row(8'h7F,      1, 1, 0, 1, 32'h7F00_0000),
      row(CH_HASH,    1, 0, 0),                     // double-quoted run
      row(CH_SQUOTE,  0, 0, 0),
      row(CH_BSLASH,  0, 0, 0),
      row(CH_SPACE,   0, 1, 0),                     // longest expansion
      row(CH_TAB,     1, 0, 0),                     // single-quoted run
      row(CH_DQUOTE,  0, 0, 0),
      row(CH_NUL,     0, 0, 0),
      row(8'h0A,      0, 0, 0),
      row(CH_SQUOTE,  0, 0, 0),
      row(8'h08,      0, 0, 0),
      row(8'h0E,      0, 0, 0),
      row(CH_HASH,    0, 0, 0),                     // hash without first mark
      row(CH_CR,      0, 0, 0),
      row(8'h00,      0, 0, 1),                     // empty word mid-run
      row(CH_SQUOTE,  0, 1, 0)
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].n, dir_tab[i].b);

    sent = 0;
    while (sent < RAND_WORDS) begin
      calm = sent >= 120 && sent < 200;
      if (sent >= 60) hold_go = 1'b1;
      if ($urandom_range(9) == 0) begin
        w = in_word_t'($urandom_range(2047));
        send_word(w);
        sent++;
      end else begin
        len = $urandom_range(6);
        if (len == 0) begin
          w = in_word_t'($urandom_range(2047));
          w.empty_word = 1'b1;
          send_word(w);
          sent++;
        end else begin
          for (int k = 0; k < len; k++) begin
            w.char_in    = pick_char(k == 0);
            w.first_byte = k == 0 && $urandom_range(19) != 0;
            w.last_byte  = k == len - 1 && $urandom_range(19) != 0;
            w.empty_word = 1'b0;
            send_word(w);
            sent++;
          end
        end
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (quoted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errs == 0 && quoted_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* conf_word_quoter_unit.f */
rtl/cwq_pkg.sv
rtl/cwq_front.sv
rtl/cwq_queue.sv
rtl/cwq_back.sv
rtl/conf_word_quoter_unit.sv
verif/testbench.sv
